@@ rtl/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 package
// S-box table, round constants and the round functions shared by the
// key expansion and the cipher datapath.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int RoundIdxW = 4;
  localparam int ApbAddrW  = 4;

  localparam logic [ApbAddrW-1:0] AddrKeyLow  = 4'h0;
  localparam logic [ApbAddrW-1:0] AddrKeyHigh = 4'h8;

  typedef logic [127:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [RoundIdxW-1:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1: r = 8'h01;
      4'd2: r = 8'h02;
      4'd3: r = 8'h04;
      4'd4: r = 8'h08;
      4'd5: r = 8'h10;
      4'd6: r = 8'h20;
      4'd7: r = 8'h40;
      4'd8: r = 8'h80;
      4'd9: r = 8'h1b;
      4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i sits in bits 8*i+7 : 8*i
  function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
    block_t n;
    logic [31:0] t;
    t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
         sbox(k[111:104]) ^ rc};
    n[31:0]   = k[31:0]   ^ t;
    n[63:32]  = k[63:32]  ^ n[31:0];
    n[95:64]  = k[95:64]  ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[(c*4+r)*8 +: 8] = sbox(s[(((c+r)%4)*4+r)*8 +: 8]);
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = s[c*32 +: 8];
      a1 = s[c*32+8 +: 8];
      a2 = s[c*32+16 +: 8];
      a3 = s[c*32+24 +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[c*32 +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
      t[c*32+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
      t[c*32+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[c*32+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

@@ rtl/aes_stream_if.sv @@
// ----------------------------------------------------------------------------
// AES block stream interface
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] low;
  logic [63:0] high;

  modport source (output valid, output low, output high, input ready);
  modport sink (input valid, input low, input high, output ready);
endinterface

@@ rtl/aes_round.sv @@
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round plus the matching key expansion step.
// ----------------------------------------------------------------------------
module aes_round (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [aes_pkg::RoundIdxW-1:0] rnd,
  input  logic                       valid_in,
  input  aes_pkg::block_t            state_in,
  input  aes_pkg::block_t            key_in,
  output logic                       valid,
  output aes_pkg::block_t            state,
  output aes_pkg::block_t            key
);
  import aes_pkg::*;

  block_t key_next;
  block_t state_next;
  block_t shifted;

  always_comb begin
    key_next = next_round_key(key_in, rcon(rnd));
    shifted  = sub_shift(state_in);
    if (rnd == RoundIdxW'(NumRounds)) begin
      state_next = shifted ^ key_next;
    end else begin
      state_next = mix_columns(shifted) ^ key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state <= state_next;
      key   <= key_next;
    end
  end
endmodule

@@ rtl/aes128_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Pipelined AES-128 encryption engine with an APB key register port.
// ----------------------------------------------------------------------------
// Usage:
//   Write key_low at byte address 0x0 and key_high at 0x8 over APB while the
//   engine is idle. Plaintext blocks enter on the in channel, ciphertext
//   blocks leave on the out channel, one per block, in order.
//   The key is captured with each block at entry and expanded alongside it,
//   one round key per stage.
//   Pipeline: one initial key-add stage and ten round stages, one round
//   each; a block is registered in every stage in order before out.valid
//   rises for it.
//   Throughput: one block per cycle while the receiver does not stall; each
//   of the eleven stages takes a new block every cycle while it advances.
//   When the receiver stalls, full stages hold while empty stages still
//   fill, so in.ready stays high while any stage is free of a block.
//   Reset clears the keys and all stage valid bits; blocks in flight drop.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [aes_pkg::ApbAddrW-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  aes_stream_if.sink  in,
  aes_stream_if.source out
);
  import aes_pkg::*;

  logic [63:0] key_low;
  logic [63:0] key_high;

  logic         vld  [NumRounds+1];
  block_t       st   [NumRounds+1];
  block_t       rk   [NumRounds+1];
  logic         adv  [NumRounds+1];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrKeyLow) begin
        key_low <= pwdata;
      end else if (paddr == AddrKeyHigh) begin
        key_high <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr == AddrKeyLow) begin
      prdata = key_low;
    end else if (paddr == AddrKeyHigh) begin
      prdata = key_high;
    end else begin
      prdata = '0;
    end
  end

  // stage i advances when the next stage can take its content or it is empty
  always_comb begin
    adv[NumRounds] = out.ready || !vld[NumRounds];
    for (int i = NumRounds - 1; i >= 0; i--) begin
      adv[i] = adv[i+1] || !vld[i];
    end
  end

  assign in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0] <= {in.high, in.low} ^ {key_high, key_low};
      rk[0] <= {key_high, key_low};
    end
  end

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes_round u_round (
      .clk      (clk),
      .rst      (rst),
      .advance  (adv[g]),
      .rnd      (RoundIdxW'(g)),
      .valid_in (vld[g-1]),
      .state_in (st[g-1]),
      .key_in   (rk[g-1]),
      .valid    (vld[g]),
      .state    (st[g]),
      .key      (rk[g])
    );
  end

  assign out.valid = vld[NumRounds];
  assign out.low   = st[NumRounds][63:0];
  assign out.high  = st[NumRounds][127:64];
endmodule

@@ bench/aes128_block_encrypt_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Streams plaintext blocks through the engine under several keys written over
// APB, predicts each ciphertext block with a behavioral AES-128 cipher and
// checks the results in order. Both channels idle at random, and the receiver
// holds off once for a long stretch so that the pipeline fills and stalls.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_tb;
  import aes_pkg::*;

  localparam int NumRandom   = 1700;
  localparam int Latency     = 11;
  localparam int IdleLimit   = 20000;
  localparam int LongHold    = 300;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
  } block_pair_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  aes_stream_if plain_if ();
  aes_stream_if cipher_if ();

  aes128_block_encrypt u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in      (plain_if.sink),
    .out     (cipher_if.source)
  );

  logic [7:0] sbox_tab [256];
  logic [63:0] key_lo, key_hi;
  block_pair_t plain_q[$];
  block_pair_t cipher_q[$];
  int gap_left;
  int stall_left;
  int hold_left;
  bit hold_req;
  bit fail;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] gmul2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gmul2(a);
    end
    return p;
  endfunction

  // build the S-box from the field inverse and the affine map
  function automatic void build_sbox();
    logic [7:0] inv, x;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++) begin
        if (a != 0 && gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      end
      x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_tab[a] = x;
    end
  endfunction

  function automatic block_pair_t encrypt_block(input block_pair_t pt);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] t0, t1, t2, t3, rc, sw, a0, a1, a2, a3, all;
    block_pair_t ct;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rk[i]     = key_lo[8*i +: 8];
      rk[8 + i] = key_hi[8*i +: 8];
      st[i]     = pt.low[8*i +: 8];
      st[8 + i] = pt.high[8*i +: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      t0 = rk[i-4]; t1 = rk[i-3]; t2 = rk[i-2]; t3 = rk[i-1];
      if (i % 16 == 0) begin
        sw = t0;
        t0 = sbox_tab[t1] ^ rc;
        t1 = sbox_tab[t2];
        t2 = sbox_tab[t3];
        t3 = sbox_tab[sw];
        rc = gmul2(rc);
      end
      rk[i]   = rk[i-16] ^ t0;
      rk[i+1] = rk[i-15] ^ t1;
      rk[i+2] = rk[i-14] ^ t2;
      rk[i+3] = rk[i-13] ^ t3;
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          tmp[c*4 + r] = sbox_tab[st[((c + r) % 4)*4 + r]];
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[c*4]   = a0 ^ all ^ gmul2(a0 ^ a1);
          st[c*4+1] = a1 ^ all ^ gmul2(a1 ^ a2);
          st[c*4+2] = a2 ^ all ^ gmul2(a2 ^ a3);
          st[c*4+3] = a3 ^ all ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[16*rnd + i];
    end
    for (int i = 0; i < 8; i++) begin
      ct.low[8*i +: 8]  = st[i];
      ct.high[8*i +: 8] = st[8 + i];
    end
    return ct;
  endfunction

  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      plain_if.valid <= 1'b0;
      plain_if.low   <= '0;
      plain_if.high  <= '0;
      gap_left       <= 0;
    end else begin
      if (plain_if.valid && plain_if.ready) begin
        cipher_q.push_back(encrypt_block(plain_q.pop_front()));
      end
      if (!plain_if.valid || plain_if.ready) begin
        if (gap_left > 0 || plain_q.size() == 0) begin
          plain_if.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          plain_if.valid <= 1'b1;
          plain_if.low   <= plain_q[0].low;
          plain_if.high  <= plain_q[0].high;
          gap_left       <= draw_gap();
        end
      end
    end
  end

  // output monitor and receiver stall
  always @(posedge clk) begin
    block_pair_t exp_ct;
    if (rst) begin
      cipher_if.ready <= 1'b0;
      stall_left      <= 0;
      hold_left       <= 0;
    end else begin
      if (cipher_if.valid && cipher_if.ready) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected transfer low=%h high=%h", $time,
                   cipher_if.low, cipher_if.high);
          fail = 1'b1;
        end else begin
          exp_ct = cipher_q.pop_front();
          if (cipher_if.low !== exp_ct.low) begin
            $display("%0t: cipher_low expected %h actual %h", $time, exp_ct.low,
                     cipher_if.low);
            fail = 1'b1;
          end
          if (cipher_if.high !== exp_ct.high) begin
            $display("%0t: cipher_high expected %h actual %h", $time, exp_ct.high,
                     cipher_if.high);
            fail = 1'b1;
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left <= LongHold;
        cipher_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        cipher_if.ready <= (hold_left == 1);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        cipher_if.ready <= (stall_left == 1);
      end else begin
        stall_left <= draw_gap();
        cipher_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (plain_if.valid && plain_if.ready) ||
        (cipher_if.valid && cipher_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_key(input logic [63:0] lo, input logic [63:0] hi);
    apb_write(AddrKeyLow, lo);
    apb_write(AddrKeyHigh, hi);
    key_lo = lo;
    key_hi = hi;
    @(posedge clk);
  endtask

  task automatic drain();
    while (plain_q.size() != 0 || cipher_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic queue_block(input logic [63:0] lo, input logic [63:0] hi);
    block_pair_t b;
    b.low  = lo;
    b.high = hi;
    plain_q.push_back(b);
  endtask

  initial begin
    logic [63:0] lo, hi;
    int kind;
    fail     = 1'b0;
    hold_req = 1'b0;
    key_lo   = '0;
    key_hi   = '0;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    plain_if.valid  = 1'b0;
    plain_if.low    = '0;
    plain_if.high   = '0;
    cipher_if.ready = 1'b0;
    build_sbox();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key (all zero) on field extremes
    queue_block(64'h0, 64'h0);
    queue_block({64{1'b1}}, {64{1'b1}});
    queue_block(64'h0, {64{1'b1}});
    queue_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    drain();

    // standard example vector key
    set_key(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908);
    queue_block(64'h7766_5544_3322_1100, 64'hffee_ddcc_bbaa_9988);
    queue_block(64'h0, 64'h0);
    queue_block({64{1'b1}}, {64{1'b1}});
    queue_block(64'h8000_0000_0000_0000, 64'h1);
    drain();

    set_key({64{1'b1}}, {64{1'b1}});
    queue_block(64'h0, 64'h0);
    queue_block({64{1'b1}}, {64{1'b1}});
    queue_block(64'h1, 64'h8000_0000_0000_0000);
    drain();

    set_key({64{1'b1}}, 64'h0);
    queue_block(64'hdead_beef_0123_4567, 64'h89ab_cdef_fedc_ba98);
    drain();

    // random phases under random keys, one long receiver hold in the second
    for (int phase = 0; phase < 5; phase++) begin
      set_key(rand64(), rand64());
      for (int n = 0; n < NumRandom / 5; n++) begin
        kind = $urandom_range(0, 19);
        lo = rand64();
        hi = rand64();
        if (kind == 0) lo = '0;
        if (kind == 1) hi = {64{1'b1}};
        queue_block(lo, hi);
      end
      if (phase == 1) hold_req = 1'b1;
      drain();
    end

    if (!fail) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
